/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

/* sv/pbpc_pkg.sv */
// ----------------------------------------------------------------------------
// pbpc_pkg
// Shared types, widths, key codes and helpers of the power button classifier.
// ----------------------------------------------------------------------------
package pbpc_pkg;

   // field widths
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned DEV_W   = 1;
   localparam int unsigned CODE_W  = 10;
   localparam int unsigned VALUE_W = 2;
   localparam int unsigned HOLD_W  = 16;
   localparam int unsigned MASK_W  = 8;

   localparam int unsigned DEVICES_DEFAULT = 2;
   localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd1000;

   // event opcodes
   typedef enum logic [KIND_W-1:0] {
      EV_KEY      = 2'd0,
      EV_SWITCH   = 2'd1,
      EV_TICK     = 2'd2,
      EV_RESERVED = 2'd3
   } event_kind_type;

   // event values
   localparam logic [VALUE_W-1:0] VAL_RELEASE = 2'd0;
   localparam logic [VALUE_W-1:0] VAL_PRESS   = 2'd1;

   // reported press kinds
   localparam logic PRESS_SHORT = 1'b0;
   localparam logic PRESS_LONG  = 1'b1;

   // key and switch codes
   localparam logic [CODE_W-1:0] KC_POWER  = 10'd116;
   localparam logic [CODE_W-1:0] KC_LSHIFT = 10'd42;
   localparam logic [CODE_W-1:0] KC_RSHIFT = 10'd54;
   localparam logic [CODE_W-1:0] KC_LCTRL  = 10'd29;
   localparam logic [CODE_W-1:0] KC_RCTRL  = 10'd97;
   localparam logic [CODE_W-1:0] KC_LALT   = 10'd56;
   localparam logic [CODE_W-1:0] KC_RALT   = 10'd100;
   localparam logic [CODE_W-1:0] KC_LMETA  = 10'd125;
   localparam logic [CODE_W-1:0] KC_RMETA  = 10'd126;
   localparam logic [CODE_W-1:0] KC_F16    = 10'd186;
   localparam logic [CODE_W-1:0] SWC_LID   = 10'd0;

   // modifier mask bits
   localparam logic [MASK_W-1:0] MASK_LSHIFT = 8'h01;
   localparam logic [MASK_W-1:0] MASK_RSHIFT = 8'h02;
   localparam logic [MASK_W-1:0] MASK_LCTRL  = 8'h04;
   localparam logic [MASK_W-1:0] MASK_RCTRL  = 8'h08;
   localparam logic [MASK_W-1:0] MASK_LALT   = 8'h10;
   localparam logic [MASK_W-1:0] MASK_RALT   = 8'h20;
   localparam logic [MASK_W-1:0] MASK_LMETA  = 8'h40;
   localparam logic [MASK_W-1:0] MASK_RMETA  = 8'h80;
   localparam logic [MASK_W-1:0] MASK_META   = 8'hC0;

   // mask bit of a modifier key, zero for any other code
   function automatic logic [MASK_W-1:0] modifier_bit(input logic [CODE_W-1:0] code);
      logic [MASK_W-1:0] bit_sel;
      bit_sel = '0;
      unique case (code)
         KC_LSHIFT: bit_sel = MASK_LSHIFT;
         KC_RSHIFT: bit_sel = MASK_RSHIFT;
         KC_LCTRL:  bit_sel = MASK_LCTRL;
         KC_RCTRL:  bit_sel = MASK_RCTRL;
         KC_LALT:   bit_sel = MASK_LALT;
         KC_RALT:   bit_sel = MASK_RALT;
         KC_LMETA:  bit_sel = MASK_LMETA;
         KC_RMETA:  bit_sel = MASK_RMETA;
         default:   bit_sel = '0;
      endcase
      return bit_sel;
   endfunction

endpackage

/* sv/pbpc_req_if.sv */
// ----------------------------------------------------------------------------
// pbpc_req_if
// Event channel: valid/ready handshake carrying one input event word.
// ----------------------------------------------------------------------------
interface pbpc_req_if
   import pbpc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    event_kind;
   logic [DEV_W-1:0]     device_index;
   logic [CODE_W-1:0]    event_code;
   logic [VALUE_W-1:0]   event_value;

   modport source (
      output valid, event_kind, device_index, event_code, event_value,
      input  ready
   );

   modport sink (
      input  valid, event_kind, device_index, event_code, event_value,
      output ready
   );
endinterface

/* sv/pbpc_rsp_if.sv */
// ----------------------------------------------------------------------------
// pbpc_rsp_if
// Report channel: valid/ready handshake carrying one press report word.
// ----------------------------------------------------------------------------
interface pbpc_rsp_if;
   logic valid;
   logic ready;
   logic press_kind;

   modport source (
      output valid, press_kind,
      input  ready
   );

   modport sink (
      input  valid, press_kind,
      output ready
   );
endinterface

/* sv/power_button_press_classifier_top.sv */
// ----------------------------------------------------------------------------
// power_button_press_classifier_top
// Classifies power button activity into short and long press reports.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries key, switch and tick event words; rsp_bus carries at most
//   one press report word per event (0 short, 1 long). csr_write_enable and
//   csr_write_data load the hold time in ticks; write it only while idle.
// Timing:
//   An accepted event word lands in the input register, is decoded there against
//   the press, countdown and modifier state, and its report is loaded into the
//   output register that drives rsp_bus.valid. One event per cycle is sustained
//   while no report is held back by a blocked output register; the state update
//   is combinational compare, decrement and mask logic.
// Reset:
//   Synchronous, active high. Clears both pipeline valid bits, the pending
//   press, the countdown and all modifier masks; hold time returns to 1000.
// Stall:
//   While a report waits in the output register, events that report nothing
//   keep flowing. An event that would report holds in the input register,
//   and req_bus.ready drops only once that register is also blocked.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module power_button_press_classifier_top
   import pbpc_pkg::*;
#(
   parameter int unsigned DEVICES = DEVICES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   pbpc_req_if.sink           req_bus,
   pbpc_rsp_if.source         rsp_bus,
   input  logic               csr_write_enable,
   input  logic [HOLD_W-1:0]  csr_write_data
);

   // device select width, wide enough to hold DEVICES itself
   localparam int unsigned DSEL_W = $clog2(DEVICES + 1);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   event_kind_type       s1_kind_ff;
   logic [DEV_W-1:0]     s1_dev_ff;
   logic [CODE_W-1:0]    s1_code_ff;
   logic [VALUE_W-1:0]   s1_value_ff;

   // classifier state
   logic [HOLD_W-1:0]    hold_ticks_ff, hold_ticks_in;
   logic                 press_pending_ff, press_pending_in;
   logic [HOLD_W-1:0]    hold_countdown_ff, hold_countdown_in;
   logic [MASK_W-1:0]    modifier_mask_ff [DEVICES];
   logic [MASK_W-1:0]    modifier_mask_in [DEVICES];

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;

   // decode
   logic [DSEL_W-1:0]    dev_ext;
   logic                 dev_ok;
   logic [MASK_W-1:0]    mask_sel;
   logic [MASK_W-1:0]    mod_bit;
   logic                 meta_only;
   logic                 res_fire;
   logic                 res_kind;
   logic                 out_free;
   logic                 s1_adv;
   logic                 req_take;

   // handshake
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_valid_ff && (!res_fire || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.press_kind = rsp_kind_ff;

   // device decode and modifier lookup
   assign dev_ext = DSEL_W'(s1_dev_ff);
   assign dev_ok  = dev_ext < DSEL_W'(DEVICES);
   assign mod_bit = modifier_bit(s1_code_ff);

   always_comb begin
      mask_sel = '0;
      for (int d = 0; d < DEVICES; d++) begin
         if (dev_ext == DSEL_W'(d)) begin
            mask_sel = modifier_mask_ff[d];
         end
      end
   end

   assign meta_only = ((mask_sel & MASK_META) != '0) && ((mask_sel & ~MASK_META) == '0);

   // event classification and next state
   always_comb begin
      res_fire          = 1'b0;
      res_kind          = PRESS_SHORT;
      press_pending_in  = press_pending_ff;
      hold_countdown_in = hold_countdown_ff;
      for (int d = 0; d < DEVICES; d++) begin
         modifier_mask_in[d] = modifier_mask_ff[d];
      end

      unique case (s1_kind_ff)
         EV_TICK: begin
            if (press_pending_ff) begin
               if (hold_countdown_ff <= HOLD_W'(1)) begin
                  res_fire = 1'b1;
                  res_kind = PRESS_LONG;
               end else begin
                  hold_countdown_in = hold_countdown_ff - HOLD_W'(1);
               end
            end
         end
         EV_SWITCH: begin
            // only lid close reports
            if (dev_ok && s1_code_ff == SWC_LID && s1_value_ff == VAL_PRESS) begin
               res_fire = 1'b1;
               res_kind = PRESS_SHORT;
            end
         end
         EV_KEY: begin
            if (dev_ok) begin
               priority if (s1_code_ff == KC_POWER) begin
                  if (s1_value_ff == VAL_PRESS) begin
                     press_pending_in  = 1'b1;
                     hold_countdown_in = (hold_ticks_ff != '0) ? hold_ticks_ff
                                                               : HOLD_W'(1);
                  end else if (s1_value_ff == VAL_RELEASE && press_pending_ff) begin
                     res_fire = 1'b1;
                     res_kind = PRESS_SHORT;
                  end
               end else if (s1_code_ff == KC_F16) begin
                  if (s1_value_ff == VAL_PRESS && meta_only) begin
                     res_fire = 1'b1;
                     res_kind = PRESS_LONG;
                  end
               end else begin
                  // modifier tracking: press or repeat sets, release clears
                  for (int d = 0; d < DEVICES; d++) begin
                     if (dev_ext == DSEL_W'(d)) begin
                        if (s1_value_ff != VAL_RELEASE) begin
                           modifier_mask_in[d] = modifier_mask_ff[d] | mod_bit;
                        end else begin
                           modifier_mask_in[d] = modifier_mask_ff[d] & ~mod_bit;
                        end
                     end
                  end
               end
            end
         end
         EV_RESERVED: begin
         end
         default: begin
         end
      endcase

      // any report drops the pending press
      if (res_fire) begin
         press_pending_in  = 1'b0;
         hold_countdown_in = '0;
      end
   end

   // register next values
   always_comb begin
      hold_ticks_in = csr_write_enable ? csr_write_data : hold_ticks_ff;

      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (s1_adv && res_fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res_kind;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff     <= HOLD_TICKS_RESET;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         press_pending_ff  <= 1'b0;
         hold_countdown_ff <= '0;
         for (int d = 0; d < DEVICES; d++) begin
            modifier_mask_ff[d] <= '0;
         end
      end else begin
         hold_ticks_ff <= hold_ticks_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (s1_adv) begin
            press_pending_ff  <= press_pending_in;
            hold_countdown_ff <= hold_countdown_in;
            for (int d = 0; d < DEVICES; d++) begin
               modifier_mask_ff[d] <= modifier_mask_in[d];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      if (req_take) begin
         s1_kind_ff  <= event_kind_type'(req_bus.event_kind);
         s1_dev_ff   <= req_bus.device_index;
         s1_code_ff  <= req_bus.event_code;
         s1_value_ff <= req_bus.event_value;
      end
   end

   // checks
   `ASSERT_NEVER(a_idle_countdown, clock, reset, !press_pending_ff && hold_countdown_ff != '0)
   `ASSERT_NEVER(a_armed_countdown, clock, reset, press_pending_ff && hold_countdown_ff == '0)
   `ASSERT_CLK(a_flow_when_free, clock, reset, (s1_valid_ff && out_free) |-> s1_adv)
   `ASSERT_CLK(a_tick_needs_press, clock, reset, (s1_adv && res_fire && s1_kind_ff == EV_TICK) |-> press_pending_ff)

endmodule
